// ===== hdl/pks_pkg.sv =====
// Shared types and constants of the pose Kalman smoother.
// Used by pks_div, pks_mul and pose_kalman_smoother_top; depends on nothing.
package pks_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CHANNELS  = 7;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int WORD_W    = 32;
    localparam int NOISE_W   = 21;
    localparam int DENOM_W   = WORD_W + 1;
    localparam int GAIN_W    = FRAC_BITS + 1;
    localparam int MAG_W     = WORD_W + 1;
    localparam int PROD_W    = MAG_W + GAIN_W;

    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

    localparam logic [WORD_W-1:0]  ONE_WORD      = WORD_W'(64'd1 << FRAC_BITS);
    localparam logic [GAIN_W-1:0]  GAIN_ONE      = GAIN_W'(64'd1 << FRAC_BITS);
    localparam logic [NOISE_W-1:0] PN_RESET      = NOISE_W'(((64'd1 << FRAC_BITS) + 5) / 10);
    localparam logic [NOISE_W-1:0] MN_RESET      = NOISE_W'(64'd1 << FRAC_BITS);
    localparam logic [PROD_W-1:0]  ROUND_HALF    = PROD_W'(64'd1 << (FRAC_BITS - 1));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DIFF,
        ST_MUL,
        ST_UPD,
        ST_COV_MUL,
        ST_COV_UPD,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/pks_div.sv =====
// Restoring divider that forms the Kalman gain floor(pp * 2^FRAC_BITS / denom).
// One compare and subtract per cycle; depends on pks_pkg.
module pks_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pks_pkg::WORD_W-1:0]   i_pp,
    input  logic [pks_pkg::DENOM_W-1:0]  i_denom,
    output logic                         o_busy,
    output logic [pks_pkg::GAIN_W-1:0]   o_quot
);
    import pks_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DENOM_W-1:0]   r_rem, n_rem;
    logic [GAIN_W-1:0]    r_quot, n_quot;
    logic                 r_bit, n_bit;
    logic [DENOM_W:0]     w_trial;

    // The dividend is pp followed by FRAC_BITS zeros. Its upper bits, pp >> 1,
    // form the starting remainder; the remaining stream is pp[0] and zeros.
    assign w_trial = {r_rem, r_bit};

    always_comb begin
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_bit  = r_bit;
        if (i_start) begin
            n_cnt  = DIV_CNT_W'(DIV_STEPS);
            n_rem  = {2'b00, i_pp[WORD_W-1:1]};
            n_quot = '0;
            n_bit  = i_pp[0];
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_bit = 1'b0;
            if (w_trial >= {1'b0, i_denom}) begin
                n_rem  = DENOM_W'(w_trial - {1'b0, i_denom});
                n_quot = {r_quot[GAIN_W-2:0], 1'b1};
            end else begin
                n_rem  = w_trial[DENOM_W-1:0];
                n_quot = {r_quot[GAIN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_bit  <= n_bit;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

// ===== hdl/pks_mul.sv =====
// Registered unsigned multiplier shared by the estimate and covariance updates.
// Depends on pks_pkg for operand widths.
module pks_mul (
    input  logic                        i_clk,
    input  logic [pks_pkg::MAG_W-1:0]   i_a,
    input  logic [pks_pkg::GAIN_W-1:0]  i_b,
    output logic [pks_pkg::PROD_W-1:0]  o_p
);
    import pks_pkg::*;

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== hdl/pose_kalman_smoother_top.sv =====
// Top level of the pose Kalman smoother: sequencer, state and ports.
// Depends on pks_pkg, pks_div and pks_mul.
//
// The block smooths a seven-channel pose (position xyz and quaternion wxyz, signed
// Q16.16) with one shared scalar covariance. Each accepted item runs the schedule
// below; a new item is accepted only from idle, after the previous item is done.
// The divider part runs the covariance prediction, the divider start, 17 steps
// that retire one quotient bit each, and a step to take the quotient. The shared
// multiplier then visits each of the seven channels with a difference, a product
// and a rounded update step, and then the covariance with a product and an update
// step. The last step hands the estimate to the output register. Because of that
// register the block takes the next item while a finished estimate waits to be
// taken; it only holds in its last step if a second estimate is done before the
// first is taken. The first item, or any item with restart set, loads the
// estimate from the measurement; the covariance is never reset by an item and
// saturates at all ones. Noise registers are written through a plain write port;
// the user must write them only while the block is idle; this is not enforced.
module pose_kalman_smoother_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [pks_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pks_pkg::NOISE_W-1:0]         i_cfg_data,
    // Measurement channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_restart,
    input  logic signed [pks_pkg::WORD_W-1:0]   i_meas_pos_x,
    input  logic signed [pks_pkg::WORD_W-1:0]   i_meas_pos_y,
    input  logic signed [pks_pkg::WORD_W-1:0]   i_meas_pos_z,
    input  logic signed [pks_pkg::WORD_W-1:0]   i_meas_quat_w,
    input  logic signed [pks_pkg::WORD_W-1:0]   i_meas_quat_x,
    input  logic signed [pks_pkg::WORD_W-1:0]   i_meas_quat_y,
    input  logic signed [pks_pkg::WORD_W-1:0]   i_meas_quat_z,
    // Estimate channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [pks_pkg::WORD_W-1:0]   o_est_pos_x,
    output logic signed [pks_pkg::WORD_W-1:0]   o_est_pos_y,
    output logic signed [pks_pkg::WORD_W-1:0]   o_est_pos_z,
    output logic signed [pks_pkg::WORD_W-1:0]   o_est_quat_w,
    output logic signed [pks_pkg::WORD_W-1:0]   o_est_quat_x,
    output logic signed [pks_pkg::WORD_W-1:0]   o_est_quat_y,
    output logic signed [pks_pkg::WORD_W-1:0]   o_est_quat_z
);
    import pks_pkg::*;

    t_state r_state, n_state;

    // Configuration registers.
    logic [NOISE_W-1:0] r_q, r_r;

    // Filter state.
    logic [WORD_W-1:0] r_est  [CHANNELS];
    logic [WORD_W-1:0] r_meas [CHANNELS];
    logic [WORD_W-1:0] r_out  [CHANNELS];
    logic [WORD_W-1:0] w_meas_in [CHANNELS];
    logic [WORD_W-1:0] r_cov;
    logic              r_init;
    logic              r_out_valid;

    // Per-item working registers.
    logic [WORD_W-1:0] r_pp;
    logic [GAIN_W-1:0] r_gain;
    logic [MAG_W-1:0]  r_mag;
    logic              r_neg;
    logic [CH_W-1:0]   r_ch;

    logic              w_in_fire;
    logic              w_load;
    logic              w_div_start;
    logic              w_div_busy;
    logic [GAIN_W-1:0] w_div_quot;
    logic [DENOM_W-1:0] w_denom;
    logic [WORD_W:0]   w_pred_sum;
    logic signed [WORD_W:0] w_diff;
    logic [MAG_W-1:0]  w_mul_a;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_round;
    logic [MAG_W-1:0]  w_delta_mag;
    logic signed [WORD_W+1:0] w_est_sum;
    logic [WORD_W-1:0] w_cov_dec;
    logic              w_last_ch;

    assign w_meas_in[0] = i_meas_pos_x;
    assign w_meas_in[1] = i_meas_pos_y;
    assign w_meas_in[2] = i_meas_pos_z;
    assign w_meas_in[3] = i_meas_quat_w;
    assign w_meas_in[4] = i_meas_quat_x;
    assign w_meas_in[5] = i_meas_quat_y;
    assign w_meas_in[6] = i_meas_quat_z;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    // A restart, or the very first item, takes the measurement as the estimate.
    assign w_load     = w_in_fire && (i_restart || !r_init);

    // Predicted covariance, saturating at all ones.
    assign w_pred_sum = {1'b0, r_cov} + (WORD_W + 1)'(r_q);
    assign w_denom    = {1'b0, r_pp} + DENOM_W'(r_r);

    // Innovation of the current channel and its magnitude.
    assign w_diff = $signed({r_meas[r_ch][WORD_W-1], r_meas[r_ch]})
                  - $signed({r_est[r_ch][WORD_W-1], r_est[r_ch]});

    // The multiplier sees the pair that the current step needs.
    assign w_mul_a = (r_state == ST_COV_MUL) ? {1'b0, r_pp} : r_mag;

    // Round the scaled innovation to nearest, ties away from zero.
    assign w_round     = w_prod + ROUND_HALF;
    assign w_delta_mag = w_round[FRAC_BITS +: MAG_W];
    assign w_est_sum   = $signed({{2{r_est[r_ch][WORD_W-1]}}, r_est[r_ch]})
                       + (r_neg ? -$signed({1'b0, w_delta_mag}) : $signed({1'b0, w_delta_mag}));

    assign w_cov_dec = w_prod[FRAC_BITS +: WORD_W];
    assign w_last_ch = (r_ch == CH_W'(CHANNELS - 1));

    pks_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_pp    (r_pp),
        .i_denom (w_denom),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    pks_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (r_gain),
        .o_p   (w_prod)
    );

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = ST_PRED;
                end
            end
            ST_PRED: begin
                n_state = ST_DIV_START;
            end
            ST_DIV_START: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!w_div_busy) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = w_last_ch ? ST_COV_MUL : ST_DIFF;
            end
            ST_COV_MUL: begin
                n_state = ST_COV_UPD;
            end
            ST_COV_UPD: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and filter state that reset defines.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q         <= PN_RESET;
            r_r         <= MN_RESET;
            r_cov       <= ONE_WORD;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_est[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PROCESS_NOISE:     r_q <= i_cfg_data;
                    REG_MEASUREMENT_NOISE: r_r <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_load) begin
                r_init <= 1'b1;
                for (int i = 0; i < CHANNELS; i++) begin
                    r_est[i] <= w_meas_in[i];
                end
            end

            if (r_state == ST_DIV_START) begin
                r_ch <= '0;
            end

            if (r_state == ST_UPD) begin
                r_est[r_ch] <= w_est_sum[WORD_W-1:0];
                if (!w_last_ch) begin
                    r_ch <= r_ch + 1'b1;
                end
            end

            if (r_state == ST_COV_UPD) begin
                r_cov <= r_pp - w_cov_dec;
            end

            if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and payload.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_meas[i] <= w_meas_in[i];
            end
        end
        if (r_state == ST_PRED) begin
            r_pp <= w_pred_sum[WORD_W] ? '1 : w_pred_sum[WORD_W-1:0];
        end
        if (r_state == ST_DIV_WAIT && !w_div_busy) begin
            // Only r = 0 with pp = 0 gives a zero divisor; the gain is then zero.
            r_gain <= (w_denom == '0) ? '0 : w_div_quot;
        end
        if (r_state == ST_DIFF) begin
            r_neg <= w_diff[WORD_W];
            r_mag <= w_diff[WORD_W] ? MAG_W'(-w_diff) : MAG_W'(w_diff);
        end
        if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_out[i] <= r_est[i];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_est_pos_x  = r_out[0];
    assign o_est_pos_y  = r_out[1];
    assign o_est_pos_z  = r_out[2];
    assign o_est_quat_w = r_out[3];
    assign o_est_quat_x = r_out[4];
    assign o_est_quat_y = r_out[5];
    assign o_est_quat_z = r_out[6];

    // The gain never exceeds one once the divider has delivered it.
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIFF) |-> (r_gain <= GAIN_ONE))
        else $error("gain above one");

    // The covariance update never grows beyond the prediction.
    a_cov_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COV_UPD) |=> (r_cov <= r_pp))
        else $error("covariance above prediction");

    // A waiting estimate is never overwritten before it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_out_ready) |=> (r_state == ST_DONE))
        else $error("output register overwritten");

    // The divider is idle whenever the channel loop runs.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIFF || r_state == ST_MUL || r_state == ST_UPD) |-> !w_div_busy)
        else $error("divider busy during channel update");

endmodule
